[rtl/lzw_byte_encoder_assert.svh]
// Assertion macros for the LZW byte encoder checker.
`ifndef LZW_BYTE_ENCODER_ASSERT_SVH
`define LZW_BYTE_ENCODER_ASSERT_SVH

// Clocked check, disabled while reset is held.
`define LZW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lzw_byte_encoder: port check failed");

// Clocked same-cycle implication, disabled while reset is held.
`define LZW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzw_byte_encoder: port implication failed");

`endif

[rtl/lzw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants of the LZW byte encoder.
// ---------------------------------------------------------------------------
package lzw_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int CODE_CLEAR        = 256;
  localparam int CODE_END          = 257;
  localparam int CODE_FIRST        = 258;
  localparam int WIDTH_INIT        = 9;
  localparam int WIDTH_DEFAULT     = 12;
  localparam int WIDTH_MIN_CFG     = 9;
  localparam logic [3:0] CFG_RESET = 4'd12;
  localparam int IN_Q_DEPTH        = 2;
  localparam int OUT_Q_DEPTH       = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;
  } out_item_t;

  // Request as handed from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       first;
  } q_item_t;

endpackage
`default_nettype wire

[rtl/lzw_byte_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_byte_encoder
// LZW compressor, variable code width, codes packed MSB first into bytes.
// ---------------------------------------------------------------------------
// Usage:
//  - Input queue: drive in_data and raise push; a request is taken at a clock
//    edge with push high and full low. is_last ends the stream and flushes.
//  - Result queue: while empty is low, out_data holds the oldest code byte;
//    pop takes it. last_of_run marks the last byte a request produced,
//    stream_end the final byte of the stream.
//  - cfg_we/cfg_wdata set the largest code width; write only while idle.
//  - A request whose string the dictionary already knows only extends the
//    prefix; otherwise a code is emitted (child RAM read, then the output
//    bytes through the packer). A stream end adds the flush bytes plus a
//    sweep of the codes assigned.
//  - A dictionary clear sweeps the code log, clearing the entry of each
//    assigned code (up to 2^MAX_CODE_BITS), while requests wait in the input queue.
//  - Reset: after rst_n rises the child table is wiped, one entry per
//    cycle, with full asserted once the input queue fills.
//  - A stalled result side backs up through the output queue into the
//    engine, then the input queue, then full.
// ---------------------------------------------------------------------------
module lzw_byte_encoder #(
  parameter int MAX_CODE_BITS = lzw_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire lzw_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output lzw_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata
);

  import lzw_pkg::*;

  // Front to back request queue.
  logic      q_pop;
  logic      q_empty;
  q_item_t   q_item;

  // Back to output queue.
  logic      o_push;
  logic      o_full;
  out_item_t o_item;

  lzw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  lzw_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .o_full    (o_full),
    .o_push    (o_push),
    .o_item    (o_item)
  );

  // Output queue decouples the packer from the consumer.
  lzw_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .din   (o_item),
    .full  (o_full),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty)
  );

endmodule
`default_nettype wire

[rtl/lzw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/lzw_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_fifo
// Small register FIFO with full and empty flags.
// ---------------------------------------------------------------------------
module lzw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lzw_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_front
// Accepts input bytes, tags the first byte of each stream, queues them.
// ---------------------------------------------------------------------------
module lzw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire lzw_pkg::in_item_t in_data,
  input  wire logic              q_pop,
  output logic                   q_empty,
  output lzw_pkg::q_item_t       q_item
);

  import lzw_pkg::*;

  logic    open_r;   // a stream is in progress (a prefix exists)
  q_item_t q_in;
  logic    accept;

  assign accept = push && !full;

  always_comb begin
    q_in.data_byte = in_data.data_byte;
    q_in.is_last   = in_data.is_last;
    q_in.first     = !open_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (accept) begin
      open_r <= !in_data.is_last;
    end
  end

  lzw_fifo #(
    .WIDTH ($bits(q_item_t)),
    .DEPTH (IN_Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_in),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

endmodule
`default_nettype wire

[rtl/lzw_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_back
// Dictionary engine and bit packer: looks up (prefix, byte), emits codes.
// ---------------------------------------------------------------------------
module lzw_back #(
  parameter int MAX_CODE_BITS = lzw_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [3:0]       cfg_wdata,
  input  wire logic             q_empty,
  input  wire lzw_pkg::q_item_t q_item,
  output logic                  q_pop,
  input  wire logic             o_full,
  output logic                  o_push,
  output lzw_pkg::out_item_t    o_item
);

  import lzw_pkg::*;

  localparam int CW    = MAX_CODE_BITS;
  localparam int AW    = CW + 8;
  localparam int NW    = CW + 1;
  localparam int ACC_W = CW + 9;

  typedef enum logic [3:0] {
    ST_WIPE, ST_IDLE, ST_LOOK, ST_DRAIN, ST_GROW,
    ST_FLP, ST_FLE, ST_PAD, ST_FIN, ST_SWEEP
  } state_t;

  state_t           state_r, ret_r, sw_ret_r;
  logic [3:0]       cfg_r;
  logic [CW-1:0]    prefix_r;
  logic [NW-1:0]    nf_r, sw_end_r, sw_k_r;
  logic [4:0]       width_r;
  logic [ACC_W-1:0] acc_r;
  logic [4:0]       cnt_r;
  logic [7:0]       byte_r, pend_r;
  logic             last_r, pend_v_r, sw_rd_v_r;
  logic [AW:0]      wipe_r;

  logic             ch_we;
  logic [AW-1:0]    ch_waddr, ch_raddr;
  logic [CW-1:0]    ch_wdata, ch_rdata;
  logic             lg_we;
  logic [CW-1:0]    lg_waddr, lg_raddr;
  logic [AW-1:0]    lg_wdata, lg_rdata;

  logic [4:0]       eff_max, wnew, push_w;
  logic [CW-1:0]    push_code;
  logic [ACC_W-1:0] acc_push;
  logic [4:0]       cnt_push;
  logic             grow_hit, can_emit, miss;
  logic [7:0]       drain_byte, pad_byte;
  logic [AW-1:0]    look_idx;
  state_t           after_item;

  always_comb begin
    eff_max = (cfg_r < 4'(WIDTH_MIN_CFG)) ? 5'(WIDTH_DEFAULT) : {1'b0, cfg_r};
    if (eff_max > 5'(CW)) begin
      eff_max = 5'(CW);
    end
  end

  assign wnew       = width_r + 5'd1;
  assign grow_hit   = (nf_r == (NW'(1) << width_r));
  assign can_emit   = !pend_v_r || !o_full;
  assign drain_byte = 8'(acc_r >> (cnt_r - 5'd8));
  assign pad_byte   = 8'(acc_r << (5'd8 - cnt_r));
  assign look_idx   = {prefix_r, byte_r};
  assign miss       = (ch_rdata == '0);
  assign after_item = last_r ? ST_FLP : ST_FIN;
  assign q_pop      = (state_r == ST_IDLE) && !q_empty;

  // Code pushed into the packer in the current state.
  always_comb begin
    push_code = prefix_r;
    push_w    = width_r;
    unique case (state_r)
      ST_GROW: begin
        push_code = CW'(CODE_CLEAR);
        push_w    = wnew;
      end
      ST_FLE: begin
        push_code = CW'(CODE_END);
      end
      default: begin
      end
    endcase
    acc_push = (acc_r << push_w) | ACC_W'(push_code);
    cnt_push = cnt_r + push_w;
  end

  // Dictionary and code-log ports.
  always_comb begin
    ch_raddr = {prefix_r, q_item.data_byte};
    ch_we    = 1'b0;
    ch_waddr = look_idx;
    ch_wdata = nf_r[CW-1:0];
    lg_we    = 1'b0;
    lg_waddr = nf_r[CW-1:0];
    lg_wdata = look_idx;
    lg_raddr = sw_k_r[CW-1:0];
    unique case (state_r)
      ST_WIPE: begin
        ch_we    = !wipe_r[AW];
        ch_waddr = wipe_r[AW-1:0];
        ch_wdata = '0;
      end
      ST_LOOK: begin
        ch_we = miss;
        lg_we = miss;
      end
      ST_SWEEP: begin
        ch_we    = sw_rd_v_r;
        ch_waddr = lg_rdata;
        ch_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // Held-back byte leaves once its successor or the item end is known.
  always_comb begin
    o_push             = 1'b0;
    o_item.out_byte    = pend_r;
    o_item.last_of_run = 1'b0;
    o_item.stream_end  = 1'b0;
    unique case (state_r)
      ST_DRAIN: o_push = (cnt_r >= 5'd8) && pend_v_r && !o_full;
      ST_PAD:   o_push = (cnt_r != '0) && pend_v_r && !o_full;
      ST_FIN: begin
        o_push             = pend_v_r && !o_full;
        o_item.last_of_run = 1'b1;
        o_item.stream_end  = last_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_WIPE;
      ret_r     <= ST_IDLE;
      sw_ret_r  <= ST_IDLE;
      wipe_r    <= '0;
      cfg_r     <= CFG_RESET;
      prefix_r  <= '0;
      nf_r      <= NW'(CODE_FIRST);
      width_r   <= 5'(WIDTH_INIT);
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
      sw_rd_v_r <= 1'b0;
      sw_k_r    <= NW'(CODE_FIRST);
      sw_end_r  <= NW'(CODE_FIRST);
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_WIPE: begin
          wipe_r <= wipe_r + 1'b1;
          if (wipe_r[AW]) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            byte_r <= q_item.data_byte;
            last_r <= q_item.is_last;
            if (q_item.first) begin
              prefix_r <= CW'(q_item.data_byte);
              state_r  <= q_item.is_last ? ST_FLP : ST_FIN;
            end else begin
              state_r <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          if (!miss) begin
            prefix_r <= ch_rdata;
            state_r  <= after_item;
          end else begin
            acc_r    <= acc_push;
            cnt_r    <= cnt_push;
            nf_r     <= nf_r + 1'b1;
            prefix_r <= CW'(byte_r);
            ret_r    <= ST_GROW;
            state_r  <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cnt_r >= 5'd8) begin
            if (can_emit) begin
              pend_r   <= drain_byte;
              pend_v_r <= 1'b1;
              cnt_r    <= cnt_r - 5'd8;
            end
          end else begin
            state_r <= ret_r;
          end
        end
        ST_GROW: begin
          state_r <= after_item;
          if (grow_hit) begin
            width_r <= wnew;
            if (wnew > eff_max) begin
              acc_r     <= acc_push;
              cnt_r     <= cnt_push;
              sw_end_r  <= nf_r;
              sw_k_r    <= NW'(CODE_FIRST);
              sw_rd_v_r <= 1'b0;
              nf_r      <= NW'(CODE_FIRST);
              width_r   <= 5'(WIDTH_INIT);
              ret_r     <= ST_SWEEP;
              sw_ret_r  <= after_item;
              state_r   <= ST_DRAIN;
            end
          end
        end
        ST_FLP: begin
          acc_r   <= acc_push;
          cnt_r   <= cnt_push;
          ret_r   <= ST_FLE;
          state_r <= ST_DRAIN;
        end
        ST_FLE: begin
          acc_r   <= acc_push;
          cnt_r   <= cnt_push;
          ret_r   <= ST_PAD;
          state_r <= ST_DRAIN;
        end
        ST_PAD: begin
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end else if (can_emit) begin
            pend_r   <= pad_byte;
            pend_v_r <= 1'b1;
            cnt_r    <= '0;
            state_r  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (can_emit) begin
            pend_v_r <= 1'b0;
            if (last_r) begin
              prefix_r  <= '0;
              cnt_r     <= '0;
              sw_end_r  <= nf_r;
              sw_k_r    <= NW'(CODE_FIRST);
              sw_rd_v_r <= 1'b0;
              nf_r      <= NW'(CODE_FIRST);
              width_r   <= 5'(WIDTH_INIT);
              sw_ret_r  <= ST_IDLE;
              state_r   <= ST_SWEEP;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          if (sw_k_r < sw_end_r) begin
            sw_k_r    <= sw_k_r + 1'b1;
            sw_rd_v_r <= 1'b1;
          end else begin
            sw_rd_v_r <= 1'b0;
            if (!sw_rd_v_r) begin
              state_r <= sw_ret_r;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Child table: (prefix, byte) -> child code, zero means none.
  lzw_ram #(
    .WIDTH (CW),
    .DEPTH (1 << AW)
  ) u_child_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  // Code log: table index each code was stored at, swept to clear the table.
  lzw_ram #(
    .WIDTH (AW),
    .DEPTH (1 << CW)
  ) u_log_ram (
    .clk   (clk),
    .we    (lg_we),
    .waddr (lg_waddr),
    .wdata (lg_wdata),
    .raddr (lg_raddr),
    .rdata (lg_rdata)
  );

endmodule
`default_nettype wire

[rtl/lzw_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lzw_chk
// Port-level checks of the LZW byte encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "lzw_byte_encoder_assert.svh"

module lzw_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               empty,
  input wire logic               pop,
  input wire lzw_pkg::out_item_t out_data
);

  `LZW_ASSERT(a_reset_empty, $rose(rst_n) |-> empty)
  `LZW_ASSERT(a_hold_valid, (!empty && !pop) |=> !empty)
  `LZW_ASSERT(a_hold_data, (!empty && !pop) |=> $stable(out_data))
  `LZW_ASSERT_IMP(a_end_is_run_end, !empty && out_data.stream_end, out_data.last_of_run)

endmodule

bind lzw_byte_encoder lzw_chk u_chk (.*);
`default_nettype wire
